// ----- rtl/core/tbo_pkg.sv -----
package tbo_pkg;

  localparam int unsigned CoordW = 20;
  localparam int unsigned TagW   = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] vert0_x;
    logic signed [CoordW-1:0] vert0_y;
    logic signed [CoordW-1:0] vert0_z;
    logic signed [CoordW-1:0] vert1_x;
    logic signed [CoordW-1:0] vert1_y;
    logic signed [CoordW-1:0] vert1_z;
    logic signed [CoordW-1:0] vert2_x;
    logic signed [CoordW-1:0] vert2_y;
    logic signed [CoordW-1:0] vert2_z;
    logic        [TagW-1:0]   item_tag;
  } tbo_in_t;

  typedef struct packed {
    logic            overlaps;
    logic [TagW-1:0] result_tag;
  } tbo_out_t;

  typedef enum logic [2:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } tbo_reg_e;

endpackage

// ----- rtl/core/triangle_box_overlap_test.sv -----
// throughput: one transaction per cycle, set by the five-stage datapath
//   (differences, products, projections, plane sums, compares)
// a stall holds every stage; the output register frees as it drains
// reset: asynchronous active low, clears valid bits and box registers to 0
module triangle_box_overlap_test (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbo_pkg::tbo_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbo_pkg::tbo_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tbo_pkg::*;

  localparam int W  = CoordW;
  localparam int DW = W + 2;       // doubled coords and edges
  localparam int PW = 2 * DW + 1;  // edge-axis products and sums
  localparam int NW = 2 * DW + 1;  // normal components
  localparam int SW = NW + DW + 3; // plane sums

  // ---------------- configuration registers ----------------
  logic signed [W-1:0] box_q [6];
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 6; r++) box_q[r] <= '0;
    end else if (cfg_wr && cfg_idx < 3'd6) begin
      box_q[cfg_idx] <= pwdata[W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegMinX, RegMinY, RegMinZ, RegMaxX, RegMaxY, RegMaxZ:
        prdata = 32'(box_q[cfg_idx]);
      default: prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // stages 1..5, all advance together when the output side is free
  logic [5:1] vld_q;
  logic       adv;

  assign adv        = !vld_q[5] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:1], in_valid_i};
    end
  end

  // ---------------- stage 1: doubled vertices, edges, half sizes ----------------
  logic signed [W-1:0]  raw [3][3];
  logic signed [DW-1:0] vd_d [3][3], vd_q [3][3];
  logic signed [DW-1:0] ed_d [3][3], ed_q [3][3];
  logic signed [DW-1:0] hd_d [3], hd_q [3];
  logic [TagW-1:0]      tag1_q;

  assign raw[0][0] = in_data_i.vert0_x;
  assign raw[0][1] = in_data_i.vert0_y;
  assign raw[0][2] = in_data_i.vert0_z;
  assign raw[1][0] = in_data_i.vert1_x;
  assign raw[1][1] = in_data_i.vert1_y;
  assign raw[1][2] = in_data_i.vert1_z;
  assign raw[2][0] = in_data_i.vert2_x;
  assign raw[2][1] = in_data_i.vert2_y;
  assign raw[2][2] = in_data_i.vert2_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hd_d[k] = DW'(box_q[k+3]) - DW'(box_q[k]);
      for (int t = 0; t < 3; t++) begin
        vd_d[t][k] = (DW'(raw[t][k]) <<< 1) - DW'(box_q[k+3]) - DW'(box_q[k]);
        ed_d[t][k] = DW'(raw[(t+1)%3][k]) - DW'(raw[t][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vd_q   <= vd_d;
      ed_q   <= ed_d;
      hd_q   <= hd_d;
      tag1_q <= in_data_i.item_tag;
    end
  end

  // ---------------- stage 2: products ----------------
  // edge-axis terms: ej*vi, ei*vj, |ej|*hi, |ei|*hj ; normal components ; vertex min and max per axis
  logic signed [PW-1:0] pa_d [3][3][3], pa_q [3][3][3];
  logic signed [PW-1:0] pb_d [3][3][3], pb_q [3][3][3];
  logic signed [PW-1:0] ra_d [3][3], ra_q [3][3];
  logic signed [PW-1:0] rb_d [3][3], rb_q [3][3];
  logic signed [NW-1:0] n2_d [3], n2_q [3];
  logic signed [DW-1:0] vd2_q [3][3], hd2_q [3];
  logic signed [DW-1:0] lo2_d [3], hi2_d [3], lo2_q [3], hi2_q [3];
  logic [TagW-1:0]      tag2_q;

  function automatic logic signed [DW-1:0] sabs(input logic signed [DW-1:0] v);
    sabs = v[DW-1] ? -v : v;
  endfunction

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        ra_d[t][k] = PW'(sabs(ed_q[t][(k+2)%3])) * PW'(hd_q[(k+1)%3]);
        rb_d[t][k] = PW'(sabs(ed_q[t][(k+1)%3])) * PW'(hd_q[(k+2)%3]);
        for (int q = 0; q < 3; q++) begin
          pa_d[t][k][q] = PW'(ed_q[t][(k+2)%3]) * PW'(vd_q[q][(k+1)%3]);
          pb_d[t][k][q] = PW'(ed_q[t][(k+1)%3]) * PW'(vd_q[q][(k+2)%3]);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      n2_d[k] = NW'(ed_q[0][(k+1)%3]) * NW'(ed_q[1][(k+2)%3])
              - NW'(ed_q[0][(k+2)%3]) * NW'(ed_q[1][(k+1)%3]);
      lo2_d[k] = vd_q[0][k];
      hi2_d[k] = vd_q[0][k];
      for (int t = 1; t < 3; t++) begin
        if (vd_q[t][k] < lo2_d[k]) lo2_d[k] = vd_q[t][k];
        if (vd_q[t][k] > hi2_d[k]) hi2_d[k] = vd_q[t][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q <= pa_d; pb_q <= pb_d; ra_q <= ra_d; rb_q <= rb_d;
      n2_q <= n2_d;
      vd2_q <= vd_q; hd2_q <= hd_q;
      lo2_q <= lo2_d; hi2_q <= hi2_d;
      tag2_q <= tag1_q;
    end
  end

  // ---------------- stage 3: axis tests, normal, plane products ----------------
  logic                 sep3_d, sep3_q;
  logic signed [NW-1:0] n_d [3], n_q [3];
  logic signed [SW-1:0] nv_d [3], nv_q [3], nh_d [3], nh_q [3];
  logic [TagW-1:0]      tag3_q;

  always_comb begin
    logic signed [PW-1:0] p, lo, hi, rad;
    sep3_d = 1'b0;
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        rad = ra_q[t][k] + rb_q[t][k];
        lo  = pa_q[t][k][0] - pb_q[t][k][0];
        hi  = lo;
        for (int q = 1; q < 3; q++) begin
          p = pa_q[t][k][q] - pb_q[t][k][q];
          if (p < lo) lo = p;
          if (p > hi) hi = p;
        end
        if (lo > rad || hi < -rad) sep3_d = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (lo2_q[k] > hd2_q[k] || hi2_q[k] < -hd2_q[k]) sep3_d = 1'b1;
      n_d[k]  = n2_q[k];
      nv_d[k] = SW'(n_d[k]) * SW'(vd2_q[0][k]);
      nh_d[k] = SW'(n_d[k]) * SW'(hd2_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sep3_q <= sep3_d; n_q <= n_d; nv_q <= nv_d; nh_q <= nh_d;
      tag3_q <= tag2_q;
    end
  end

  // ---------------- stage 4: plane extents ----------------
  // box radius along the normal is the sum of n*h with the sign of n folded in
  logic                 sep4_q;
  logic signed [SW-1:0] smin_d, smax_d, smin_q, smax_q;
  logic [TagW-1:0]      tag4_q;

  always_comb begin
    logic signed [SW-1:0] dsum, hsum;
    dsum = (nv_q[0] + nv_q[1]) + nv_q[2];
    hsum = ((n_q[0] > 0) ? nh_q[0] : -nh_q[0])
         + (((n_q[1] > 0) ? nh_q[1] : -nh_q[1]) + ((n_q[2] > 0) ? nh_q[2] : -nh_q[2]));
    smin_d = -(dsum + hsum);
    smax_d = hsum - dsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sep4_q <= sep3_q; smin_q <= smin_d; smax_q <= smax_d; tag4_q <= tag3_q;
    end
  end

  // ---------------- stage 5: output register ----------------
  tbo_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.overlaps   <= !sep4_q && !(smin_q > 0) && !smax_q[SW-1];
      out_q.result_tag <= tag4_q;
    end
  end

  assign out_valid_o = vld_q[5];
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted transaction lost");

endmodule

// ----- test/triangle_box_overlap_test_tb.sv -----
module triangle_box_overlap_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbo_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam longint CoordMax = 524287;
  localparam longint CoordMin = -524288;
  localparam int     DrainCycles = 12;
  localparam longint CycleLimit  = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  tbo_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tbo_out_t out_data_o;
  logic     psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  triangle_box_overlap_test u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // box corners as the testbench believes them to be
  longint   box_corner [6];
  // overlap results still owed by the block, oldest first
  tbo_out_t owed_results [$];
  int       fails = 0;
  bit       allow_idle = 1;
  longint   cycle_count = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // separating axis test in exact wide arithmetic
  function automatic bit predict_overlap(tbo_in_t it);
    longint raw [3][3];
    longint vd [3][3];
    longint ed [3][3];
    longint hd [3];
    longint mn, mx, a, b;
    wide_t  lo, hi, rad, p, d, smin, smax, m;
    wide_t  n [3];
    int     i, j;
    bit     hit;
    hit = 1;
    raw[0][0] = longint'(it.vert0_x);
    raw[0][1] = longint'(it.vert0_y);
    raw[0][2] = longint'(it.vert0_z);
    raw[1][0] = longint'(it.vert1_x);
    raw[1][1] = longint'(it.vert1_y);
    raw[1][2] = longint'(it.vert1_z);
    raw[2][0] = longint'(it.vert2_x);
    raw[2][1] = longint'(it.vert2_y);
    raw[2][2] = longint'(it.vert2_z);
    for (int k = 0; k < 3; k++) begin
      mn = box_corner[k];
      mx = box_corner[k+3];
      hd[k] = mx - mn;
      for (int t = 0; t < 3; t++) begin
        vd[t][k] = 2 * raw[t][k] - (mx + mn);
        ed[t][k] = raw[(t+1)%3][k] - raw[t][k];
      end
    end
    // edge cross box axis projections
    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 3; k++) begin
        i = (k + 1) % 3;
        j = (k + 2) % 3;
        a = ed[t][j] < 0 ? -ed[t][j] : ed[t][j];
        b = ed[t][i] < 0 ? -ed[t][i] : ed[t][i];
        rad = wide_t'(a) * wide_t'(hd[i]) + wide_t'(b) * wide_t'(hd[j]);
        for (int q = 0; q < 3; q++) begin
          p = wide_t'(ed[t][j]) * wide_t'(vd[q][i]) - wide_t'(ed[t][i]) * wide_t'(vd[q][j]);
          if (q == 0 || p < lo) lo = p;
          if (q == 0 || p > hi) hi = p;
        end
        if (lo > rad || hi < -rad) hit = 0;
      end
    end
    // box face normals
    for (int k = 0; k < 3; k++) begin
      lo = wide_t'(vd[0][k]);
      hi = wide_t'(vd[0][k]);
      for (int t = 1; t < 3; t++) begin
        if (wide_t'(vd[t][k]) < lo) lo = wide_t'(vd[t][k]);
        if (wide_t'(vd[t][k]) > hi) hi = wide_t'(vd[t][k]);
      end
      if (lo > wide_t'(hd[k]) || hi < -wide_t'(hd[k])) hit = 0;
    end
    // triangle plane against nearest and farthest corners
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      n[k] = wide_t'(ed[0][i]) * wide_t'(ed[1][j]) - wide_t'(ed[0][j]) * wide_t'(ed[1][i]);
    end
    d = 0;
    for (int k = 0; k < 3; k++) d = d - n[k] * wide_t'(vd[0][k]);
    smin = d;
    smax = d;
    for (int k = 0; k < 3; k++) begin
      m = n[k] * wide_t'(hd[k]);
      if (n[k] > 0) begin
        smin = smin - m;
        smax = smax + m;
      end else begin
        smin = smin + m;
        smax = smax - m;
      end
    end
    if (smin > 0 || smax < 0) hit = 0;
    return hit;
  endfunction

  function automatic tbo_in_t make_tri(longint c [9], logic [15:0] tag);
    tbo_in_t it;
    it.vert0_x = CoordW'(c[0]); it.vert0_y = CoordW'(c[1]); it.vert0_z = CoordW'(c[2]);
    it.vert1_x = CoordW'(c[3]); it.vert1_y = CoordW'(c[4]); it.vert1_z = CoordW'(c[5]);
    it.vert2_x = CoordW'(c[6]); it.vert2_y = CoordW'(c[7]); it.vert2_z = CoordW'(c[8]);
    it.item_tag = tag;
    return it;
  endfunction

  // apb write: setup cycle then access cycle
  task automatic write_corner(tbo_reg_e idx, longint value);
    @(negedge clk_i);
    psel   <= 1;
    pwrite <= 1;
    paddr  <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    box_corner[idx] = longint'(signed'(pwdata[19:0]));
    @(negedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic set_box(longint c [6]);
    write_corner(RegMinX, c[0]);
    write_corner(RegMinY, c[1]);
    write_corner(RegMinZ, c[2]);
    write_corner(RegMaxX, c[3]);
    write_corner(RegMaxY, c[4]);
    write_corner(RegMaxZ, c[5]);
  endtask

  // offer one triangle; valid stays high into the next one
  task automatic send_tri(tbo_in_t it, bit fixed_chk, bit fixed_exp);
    tbo_out_t r;
    if (allow_idle) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r.overlaps   = fixed_chk ? fixed_exp : predict_overlap(it);
    r.result_tag = it.item_tag;
    owed_results = {owed_results, r};
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic longint near_coord(longint lo_c, longint hi_c);
    longint ctr, span, v;
    ctr  = (lo_c + hi_c) / 2;
    span = (hi_c > lo_c ? hi_c - lo_c : lo_c - hi_c) + 16;
    v = ctr + longint'($urandom_range(32'(2 * span))) - span;
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v;
  endfunction

  task automatic random_phase(int count);
    longint c [9];
    tbo_in_t it;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        // raw noise over the full coordinate range
        for (int q = 0; q < 9; q++) c[q] = longint'(signed'(20'($urandom)));
      end else begin
        for (int q = 0; q < 9; q++) c[q] = near_coord(box_corner[q%3], box_corner[q%3+3]);
      end
      it = make_tri(c, 16'($urandom));
      send_tri(it, 0, 0);
    end
  endtask

  // receiver side stalls at random
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !(allow_idle && $urandom_range(99) < 6);
  end

  // compare each result transaction with the oldest owed one
  always @(posedge clk_i) begin
    tbo_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        $error("result transaction with nothing owed, tag %h", out_data_o.result_tag);
        fails++;
      end else begin
        want = owed_results.pop_front();
        if (out_data_o.overlaps !== want.overlaps) begin
          $error("overlaps: expected %b actual %b (tag %h)", want.overlaps,
                 out_data_o.overlaps, want.result_tag);
          fails++;
        end
        if (out_data_o.result_tag !== want.result_tag) begin
          $error("result_tag: expected %h actual %h", want.result_tag,
                 out_data_o.result_tag);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("triangle_box_overlap_test_tb failed");
      $finish;
    end
  end

  typedef struct {
    tbo_in_t tri_in;
    bit      chk;
    bit      exp_hit;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    longint c [9];
    longint bx [6];
    rst_ni      = 0;
    in_valid_i  = 0;
    in_data_i   = '0;
    out_ready_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    foreach (box_corner[k]) box_corner[k] = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;

    // directed table against the reset box, a single point at the origin
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    row = '{make_tri(c, 16'h0000), 1, 1}; rows = {rows, row};
    c = '{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
          CoordMax};
    row = '{make_tri(c, 16'hffff), 1, 0}; rows = {rows, row};
    c = '{CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
          CoordMin};
    row = '{make_tri(c, 16'h5a5a), 1, 0}; rows = {rows, row};
    // touching at a corner counts as overlap
    c = '{0, 0, 0, 100, 0, 0, 0, 100, 0};
    row = '{make_tri(c, 16'h0001), 1, 1}; rows = {rows, row};
    c = '{CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax, CoordMin, 0};
    row = '{make_tri(c, 16'h8000), 0, 0}; rows = {rows, row};
    c = '{CoordMin, CoordMax, 0, CoordMax, CoordMin, 0, 0, 0, CoordMax};
    row = '{make_tri(c, 16'h7fff), 0, 0}; rows = {rows, row};
    // degenerate: collinear, and a repeated vertex
    c = '{-50, -50, -50, 50, 50, 50, 100, 100, 100};
    row = '{make_tri(c, 16'h0002), 0, 0}; rows = {rows, row};
    c = '{-10, 5, 3, -10, 5, 3, 20, -7, 1};
    row = '{make_tri(c, 16'h0003), 0, 0}; rows = {rows, row};
    // plane just misses the origin
    c = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    row = '{make_tri(c, 16'h0004), 0, 0}; rows = {rows, row};
    c = '{-1, -1, 1, 1, -1, 1, 0, 2, 1};
    row = '{make_tri(c, 16'h0005), 0, 0}; rows = {rows, row};
    foreach (rows[r]) send_tri(rows[r].tri_in, rows[r].chk, rows[r].exp_hit);
    wait_idle();

    // full range box, edges and plane at their widest
    bx = '{CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax};
    set_box(bx);
    random_phase(150);
    wait_idle();

    // modest box, with no idling on either side
    bx = '{-2048, -1024, -4096, 2048, 3072, 1024};
    set_box(bx);
    allow_idle = 0;
    random_phase(250);
    wait_idle();
    allow_idle = 1;

    // inverted box: negative half sizes used as they stand
    bx = '{3000, -500, 800, -3000, 500, -800};
    set_box(bx);
    random_phase(150);
    wait_idle();

    // thin box, zero width in z
    bx = '{-300, -300, 77, 300, 300, 77};
    set_box(bx);
    random_phase(150);
    wait_idle();

    // random boxes, some inverted by chance
    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 6; k++) bx[k] = longint'($urandom_range(20000)) - 10000;
      set_box(bx);
      random_phase(150);
      wait_idle();
    end

    if (fails == 0) begin
      $display("triangle_box_overlap_test_tb passed");
    end else begin
      $display("triangle_box_overlap_test_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tbo_pkg.sv
rtl/core/triangle_box_overlap_test.sv
test/triangle_box_overlap_test_tb.sv
